// ===== design/wass_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wass_pkg
// shared constants and types of the weighted aligned slice splitter
// ----------------------------------------------------------------------------
package wass_pkg;

    localparam int MAX_WORKERS = 8;
    localparam int WEIGHT_BITS = 8;
    localparam int ALIGN_BYTES = 32;

    localparam int ROW_W    = 32;
    localparam int WIDX_W   = 4;
    localparam int CNT_W    = 4;
    localparam int RWGT_W   = 64;
    localparam int WSUM_W   = WEIGHT_BITS + $clog2(MAX_WORKERS + 1);
    localparam int PROD_W   = ROW_W + WSUM_W;
    localparam int S_DATA_W = ((ROW_W + WIDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((1 + 2 * ROW_W + 7) / 8) * 8;
    localparam int Q_DEPTH  = 4;
    localparam int Q_PTR_W  = $clog2(Q_DEPTH);
    localparam int Q_CNT_W  = $clog2(Q_DEPTH + 1);

    // alignment is a power of two, so rounding down is a mask
    localparam logic [ROW_W-1:0] ALIGN_MASK = ROW_W'(ALIGN_BYTES - 1);

    typedef enum logic {
        REG_WORKER_COUNT  = 1'b0,
        REG_ROUTE_WEIGHTS = 1'b1
    } cfg_reg_t;

    // one classified request between front and back
    typedef struct packed {
        logic              bad;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [WSUM_W-1:0] total;
        logic [PROD_W-1:0] num_begin;
        logic [PROD_W-1:0] num_end;
    } wass_item_t;

    // one divider stage
    typedef struct packed {
        logic              bad;
        logic              last;
        logic [ROW_W-1:0]  row;
        logic [WSUM_W-1:0] total;
        logic [PROD_W-1:0] num_begin;
        logic [PROD_W-1:0] num_end;
        logic [WSUM_W-1:0] rem_begin;
        logic [WSUM_W-1:0] rem_end;
        logic [ROW_W-1:0]  quo_begin;
        logic [ROW_W-1:0]  quo_end;
    } wass_div_t;

endpackage
`default_nettype wire

// ===== design/wass_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wass_front
// config registers, request checks, weight prefix sums and the two products
// ----------------------------------------------------------------------------
module wass_front
    import wass_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_addr,
    input  wire logic [RWGT_W-1:0]   cfg_wr_data,
    input  wire logic                in_valid,
    input  wire logic [ROW_W-1:0]    in_row,
    input  wire logic [WIDX_W-1:0]   in_who,
    input  wire logic                advance,
    output wire logic                out_valid,
    output wass_item_t               out_item
);

    logic [CNT_W-1:0]  worker_count_reg;
    logic [RWGT_W-1:0] route_weights_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            worker_count_reg  <= CNT_W'(1);
            route_weights_reg <= RWGT_W'(1);
        end else if (cfg_wr_en) begin
            case (cfg_reg_t'(cfg_addr))
                REG_WORKER_COUNT:  worker_count_reg  <= cfg_wr_data[CNT_W-1:0];
                REG_ROUTE_WEIGHTS: route_weights_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // stage a: checks and prefix sums
    logic [RWGT_W+WEIGHT_BITS-1:0] wext;
    logic [WSUM_W-1:0] pre_s, incl_s, total_s;
    logic zero_w, bad_s, last_s;

    always_comb begin
        logic [WEIGHT_BITS-1:0] w;
        wext    = {{WEIGHT_BITS{1'b0}}, route_weights_reg};
        pre_s   = '0;
        incl_s  = '0;
        total_s = '0;
        zero_w  = 1'b0;
        for (int i = 0; i < MAX_WORKERS; i++) begin
            if (i * WEIGHT_BITS < RWGT_W) w = wext[i*WEIGHT_BITS +: WEIGHT_BITS];
            else w = '0;
            if (CNT_W'(i) < worker_count_reg) begin
                if (w == '0) zero_w = 1'b1;
                if (WIDX_W'(i) < in_who) pre_s = pre_s + WSUM_W'(w);
                if (WIDX_W'(i) <= in_who) incl_s = incl_s + WSUM_W'(w);
                total_s = total_s + WSUM_W'(w);
            end
        end
        bad_s = (in_row == '0) || ((in_row & ALIGN_MASK) != '0) ||
                (worker_count_reg == '0) ||
                ({1'b0, worker_count_reg} > (CNT_W+1)'(MAX_WORKERS)) ||
                ({1'b0, in_who} >= {1'b0, worker_count_reg}) || zero_w;
        last_s = ({1'b0, in_who} + (WIDX_W+1)'(1)) == {1'b0, worker_count_reg};
    end

    logic              a_valid_reg;
    logic              a_bad_reg, a_last_reg;
    logic [ROW_W-1:0]  a_row_reg;
    logic [WSUM_W-1:0] a_pre_reg, a_incl_reg, a_total_reg;
    logic              b_valid_reg;
    wass_item_t        b_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end else if (advance) begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            a_bad_reg   <= bad_s;
            a_last_reg  <= last_s;
            a_row_reg   <= in_row;
            a_pre_reg   <= pre_s;
            a_incl_reg  <= incl_s;
            a_total_reg <= total_s;
            b_item_reg.bad       <= a_bad_reg;
            b_item_reg.last      <= a_last_reg;
            b_item_reg.row       <= a_row_reg;
            b_item_reg.total     <= a_total_reg;
            b_item_reg.num_begin <= PROD_W'(a_row_reg) * PROD_W'(a_pre_reg);
            b_item_reg.num_end   <= PROD_W'(a_row_reg) * PROD_W'(a_incl_reg);
        end
    end

    assign out_valid = b_valid_reg;
    assign out_item  = b_item_reg;

endmodule
`default_nettype wire

// ===== design/wass_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wass_queue
// short fifo between front and back
// ----------------------------------------------------------------------------
module wass_queue
    import wass_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        push,
    input  wire wass_item_t  push_item,
    input  wire logic        pop,
    output wire logic        full,
    output wire logic        empty,
    output wass_item_t       head
);

    wass_item_t         mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg;

    assign full  = count_reg == Q_CNT_W'(Q_DEPTH);
    assign empty = count_reg == '0;
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(1);
            if (pop)  rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            if (push && !pop) count_reg <= count_reg + Q_CNT_W'(1);
            else if (pop && !push) count_reg <= count_reg - Q_CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_item;
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push) else $error("queue push while full");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        empty |-> !pop) else $error("queue pop while empty");
    a_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (push && !pop) |=> count_reg == $past(count_reg) + Q_CNT_W'(1))
        else $error("queue count did not follow push");

endmodule
`default_nettype wire

// ===== design/wass_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// wass_back
// pipelined restoring divider, one quotient bit per stage, then alignment
// ----------------------------------------------------------------------------
module wass_back
    import wass_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               in_valid,
    input  wire wass_item_t         in_item,
    output wire logic               pop,
    output wire logic               m_valid,
    input  wire logic               m_ready,
    output wire logic [M_DATA_W-1:0] m_data
);

    wass_div_t st [ROW_W+1];
    logic      vld [ROW_W+1];
    logic      advance;
    logic      out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    assign advance = !(out_valid_reg && !m_ready);
    assign pop     = advance && in_valid;

    // numerator over 2^32 stays below total, so the top bits seed the remainder
    always_comb begin
        st[0].bad       = in_item.bad;
        st[0].last      = in_item.last;
        st[0].row       = in_item.row;
        st[0].total     = in_item.total;
        st[0].num_begin = in_item.num_begin;
        st[0].num_end   = in_item.num_end;
        st[0].rem_begin = in_item.num_begin[PROD_W-1:ROW_W];
        st[0].rem_end   = in_item.num_end[PROD_W-1:ROW_W];
        st[0].quo_begin = '0;
        st[0].quo_end   = '0;
        vld[0]          = in_valid;
    end

    for (genvar s = 0; s < ROW_W; s++) begin : g_div
        wass_div_t nxt;
        always_comb begin
            logic [WSUM_W:0] tb, te;
            nxt = st[s];
            tb  = {st[s].rem_begin, st[s].num_begin[ROW_W-1-s]};
            te  = {st[s].rem_end, st[s].num_end[ROW_W-1-s]};
            if (tb >= {1'b0, st[s].total}) begin
                tb = tb - {1'b0, st[s].total};
                nxt.quo_begin[ROW_W-1-s] = 1'b1;
            end
            if (te >= {1'b0, st[s].total}) begin
                te = te - {1'b0, st[s].total};
                nxt.quo_end[ROW_W-1-s] = 1'b1;
            end
            nxt.rem_begin = tb[WSUM_W-1:0];
            nxt.rem_end   = te[WSUM_W-1:0];
        end
        always_ff @(posedge aclk) begin
            if (!aresetn) vld[s+1] <= 1'b0;
            else if (advance) vld[s+1] <= vld[s];
        end
        always_ff @(posedge aclk) begin
            if (advance) st[s+1] <= nxt;
        end
    end

    logic [ROW_W-1:0] beg_a, end_a;
    logic             ok;
    always_comb begin
        beg_a = st[ROW_W].quo_begin & ~ALIGN_MASK;
        end_a = st[ROW_W].last ? st[ROW_W].row : (st[ROW_W].quo_end & ~ALIGN_MASK);
        ok    = !st[ROW_W].bad && (beg_a <= end_a) && (end_a <= st[ROW_W].row);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) out_valid_reg <= 1'b0;
        else if (advance) out_valid_reg <= vld[ROW_W];
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            if (ok) out_data_reg <= M_DATA_W'({end_a - beg_a, beg_a, 1'b1});
            else    out_data_reg <= '0;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |=> $stable(out_data_reg))
        else $error("result changed while stalled");
    a_pop_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> (in_valid && advance)) else $error("pop without room");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_data_reg[0]) |-> (out_data_reg == '0))
        else $error("invalid slice with nonzero fields");

endmodule
`default_nettype wire

// ===== design/weighted_aligned_slice_split.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// weighted_aligned_slice_split
// splits a row among weighted workers and gives one worker's aligned slice
// ----------------------------------------------------------------------------
//  channel  dir   handshake               payload
//  s_       in    s_tvalid / s_tready     s_tdata: row_bytes, worker_index
//  m_       out   m_tvalid / m_tready     m_tdata: slice_valid, offset, length
//  cfg_     in    cfg_wr_en               cfg_addr, cfg_wr_data
//
//  one request per cycle sustained while nothing stalls; a request passes front
//  stages a and b, the queue, 32 divider stages (one quotient bit each) and the output register
//  the front stalls only when the 4-entry queue is full, the back only when
//  the output register holds an untaken result
//  reset is synchronous active low; config resets to one worker, weight 1
// ----------------------------------------------------------------------------
module weighted_aligned_slice_split
    import wass_pkg::*;
(
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_wr_en,
    input  wire logic                cfg_addr,
    input  wire logic [RWGT_W-1:0]   cfg_wr_data,
    input  wire logic                s_tvalid,
    output wire logic                s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,   // row_bytes, worker_index
    output wire logic                m_tvalid,
    input  wire logic                m_tready,
    output wire logic [M_DATA_W-1:0] m_tdata    // slice_valid, slice_offset, slice_length
);

    logic       q_full, q_empty, f_valid, pop;
    wass_item_t f_item, q_head;

    assign s_tready = !q_full;

    wass_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_row      (s_tdata[ROW_W-1:0]),
        .in_who      (s_tdata[ROW_W +: WIDX_W]),
        .advance     (!q_full),
        .out_valid   (f_valid),
        .out_item    (f_item)
    );

    wass_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (f_valid && !q_full),
        .push_item (f_item),
        .pop       (pop),
        .full      (q_full),
        .empty     (q_empty),
        .head      (q_head)
    );

    wass_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (!q_empty),
        .in_item  (q_head),
        .pop      (pop),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_data   (m_tdata)
    );

endmodule
`default_nettype wire
